// ===== hdl/ttn_pkg.sv =====
// Shared constants, types and byte-class functions of the text token normalizer.
package ttn_pkg;

  localparam int unsigned TOKEN_MAX = 32;
  localparam int unsigned LEN_W     = $clog2(TOKEN_MAX + 1);
  localparam int unsigned IDX_W     = $clog2(TOKEN_MAX);
  localparam int unsigned TUSER_W   = 3;

  localparam logic [7:0] RPT_LIMIT_RST = 8'd2;
  localparam logic [7:0] SPACE_CHAR    = 8'h20;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef struct packed {
    logic accept;
    logic init_walk;
    logic set_any;
    logic put_space;
    logic rd;
    logic emit_cur;
    logic advance;
    logic flush;
    logic marker;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic tok_end;
    logic nonempty;
    logic any_emitted;
    logic drop;
    logic can_produce;
    logic out_free;
    logic pend_valid;
    logic eot;
    logic walk_last;
  } sts_t;

  function automatic logic is_upper(logic [7:0] c);
    return c inside {[8'h41:8'h5A]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_sub(logic [7:0] c);
    return c inside {8'h40, 8'h2A, 8'h34, 8'h38, 8'h28, 8'h3C, 8'h33, 8'h39, 8'h36,
                     8'h23, 8'h31, 8'h21, 8'h7C, 8'h3B, 8'h30, 8'h24, 8'h35, 8'h37,
                     8'h2B, 8'h76, 8'h32, 8'hCE, 8'hB2, 8'hC3, 8'hA7, 8'hE2, 8'h88,
                     8'h82, 8'hAC, 8'hB5, 8'hCF, 8'h86, 8'hC4, 8'hBA, 8'hC2, 8'hB8,
                     8'h81, 8'hAE, 8'h97, 8'hA5, 8'hB1};
  endfunction

endpackage

// ===== hdl/ttn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ttn_ctrl.sv =====
// Controller state machine: byte intake, token release walk and result closing.
module ttn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  ttn_pkg::sts_t sts_i,
  output ttn_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SPACE = 5'b00010,
    S_READ  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.accept    = s_axis_tvalid_i;
        if (s_axis_tvalid_i && sts_i.tok_end) begin
          state_d = S_SPACE;
        end
      end
      S_SPACE: begin
        cmd_o.init_walk = 1'b1;
        if (!sts_i.nonempty) begin
          state_d = S_FIN;
        end else if (!sts_i.any_emitted) begin
          cmd_o.set_any = 1'b1;
          state_d       = S_READ;
        end else if (sts_i.can_produce) begin
          cmd_o.put_space = 1'b1;
          cmd_o.set_any   = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.drop || sts_i.can_produce) begin
          cmd_o.emit_cur = !sts_i.drop;
          cmd_o.advance  = 1'b1;
          state_d        = sts_i.walk_last ? S_FIN : S_READ;
        end
      end
      S_FIN: begin
        if (sts_i.pend_valid) begin
          if (sts_i.out_free) begin
            cmd_o.flush = 1'b1;
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (sts_i.eot) begin
          if (sts_i.out_free) begin
            cmd_o.marker = 1'b1;
            cmd_o.clear  = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_tok_end_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && s_axis_tvalid_i && sts_i.tok_end) |=> (state_q == S_SPACE))
    else $error("token end not followed by release walk");

  a_drop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && sts_i.drop) |=> (state_q == S_READ || state_q == S_FIN))
    else $error("dropped byte stalled the walk");

endmodule

// ===== hdl/ttn_dp.sv =====
// Datapath: repeat filter, token buffer with class tracking, walk logic and output stage.
module ttn_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  input  logic                        cfg_we_i,
  input  logic [7:0]                  cfg_wdata_i,
  input  logic                        m_axis_tready_i,
  output logic                        m_axis_tvalid_o,
  output logic [7:0]                  m_axis_tdata_o,
  output logic                        m_axis_tlast_o,
  output logic [ttn_pkg::TUSER_W-1:0] m_axis_tuser_o,
  input  ttn_pkg::cmd_t               cmd_i,
  output ttn_pkg::sts_t               sts_o
);

  localparam int unsigned LEN_W = ttn_pkg::LEN_W;
  localparam int unsigned IDX_W = ttn_pkg::IDX_W;

  // repeat filter and text state
  logic [7:0]       max_rep_q;
  logic [7:0]       prev_q;
  logic [7:0]       rcnt_q;
  logic             any_q;
  logic             eot_q;
  // token buffer tracking
  logic [LEN_W-1:0] tok_len_q;
  logic             ovf_q;
  logic             seen_q;
  logic [IDX_W-1:0] lo_q;
  logic [LEN_W-1:0] hi_q;
  logic             p1_in_q, p1_alpha_q, p2_alpha_q;
  logic [IDX_W-1:0] rs_q;
  logic [1:0]       runcnt_q;
  logic             sand_q [ttn_pkg::TOKEN_MAX];
  logic             obf_q  [ttn_pkg::TOKEN_MAX];
  // walk
  logic [IDX_W-1:0] idx_q;
  logic             w_in_q, w_obf_q;
  // pending result and output register
  logic             pend_v_q;
  logic [7:0]       pend_byte_q;
  logic             pend_trunc_q;
  logic             out_v_q;
  logic [7:0]       out_byte_q;
  logic             out_has_q, out_last_q, out_done_q, out_trunc_q;

  logic [7:0]       c_low;
  logic             same, keep, c_space, buf_wr;
  logic [IDX_W-1:0] wr_idx;
  logic             c_alpha, c_sub, c_keep, cur_in, run_start, sandwich;
  logic [1:0]       runcnt_d;
  logic [IDX_W-1:0] rs_d;
  logic [7:0]       rd_byte;
  logic             b_alpha, b_sub;
  logic             out_free, can_produce, produce, load_pend;
  logic [7:0]       prod_byte;

  ttn_ram #(
    .WIDTH (8),
    .DEPTH (ttn_pkg::TOKEN_MAX)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_wr),
    .waddr_i (wr_idx),
    .wdata_i (c_low),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rd_byte)
  );

  always_comb begin
    c_low   = ttn_pkg::is_upper(s_axis_tdata_i) ? s_axis_tdata_i + ttn_pkg::CASE_OFFSET
                                                 : s_axis_tdata_i;
    same    = (c_low == prev_q);
    keep    = !same || (rcnt_q < max_rep_q);
    c_space = ttn_pkg::is_space(c_low);
    buf_wr  = cmd_i.accept && keep && !c_space && (tok_len_q < LEN_W'(ttn_pkg::TOKEN_MAX));
    wr_idx  = tok_len_q[IDX_W-1:0];

    c_alpha   = ttn_pkg::is_alpha(c_low);
    c_sub     = ttn_pkg::is_sub(c_low);
    c_keep    = c_alpha || ttn_pkg::is_digit(c_low) || c_sub;
    cur_in    = c_alpha || (p1_in_q && c_sub);
    run_start = c_alpha && !p1_in_q;
    // previous byte is a lone non-letter between two letters of the run
    sandwich  = c_alpha && p1_in_q && !p1_alpha_q && p2_alpha_q;
    rs_d      = run_start ? wr_idx : rs_q;
    if (run_start) begin
      runcnt_d = 2'd0;
    end else if (sandwich && runcnt_q != 2'd2) begin
      runcnt_d = runcnt_q + 2'd1;
    end else begin
      runcnt_d = runcnt_q;
    end

    b_alpha = ttn_pkg::is_alpha(rd_byte);
    b_sub   = ttn_pkg::is_sub(rd_byte);

    out_free    = !out_v_q || m_axis_tready_i;
    can_produce = !pend_v_q || out_free;
    produce     = cmd_i.put_space || cmd_i.emit_cur;
    prod_byte   = cmd_i.put_space ? ttn_pkg::SPACE_CHAR : rd_byte;
    load_pend   = (produce && pend_v_q) || cmd_i.flush;

    sts_o.tok_end     = (keep && c_space) || s_axis_tlast_i;
    sts_o.nonempty    = seen_q;
    sts_o.any_emitted = any_q;
    sts_o.drop        = w_obf_q && sand_q[idx_q];
    sts_o.can_produce = can_produce;
    sts_o.out_free    = out_free;
    sts_o.pend_valid  = pend_v_q;
    sts_o.eot         = eot_q;
    sts_o.walk_last   = ((LEN_W'(idx_q) + LEN_W'(1)) == hi_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rep_q  <= ttn_pkg::RPT_LIMIT_RST;
      prev_q     <= '0;
      rcnt_q     <= '0;
      any_q      <= 1'b0;
      eot_q      <= 1'b0;
      tok_len_q  <= '0;
      ovf_q      <= 1'b0;
      seen_q     <= 1'b0;
      lo_q       <= '0;
      hi_q       <= '0;
      p1_in_q    <= 1'b0;
      p1_alpha_q <= 1'b0;
      p2_alpha_q <= 1'b0;
      rs_q       <= '0;
      runcnt_q   <= '0;
      idx_q      <= '0;
      w_in_q     <= 1'b0;
      w_obf_q    <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_rep_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        eot_q <= s_axis_tlast_i;
        if (!same) begin
          prev_q <= c_low;
          rcnt_q <= 8'd1;
        end else if (keep) begin
          rcnt_q <= rcnt_q + 8'd1;
        end
        if (keep && !c_space && !buf_wr) begin
          ovf_q <= 1'b1;
        end
      end
      if (buf_wr) begin
        tok_len_q  <= tok_len_q + LEN_W'(1);
        p1_in_q    <= cur_in;
        p1_alpha_q <= c_alpha;
        p2_alpha_q <= p1_alpha_q;
        if (cur_in) begin
          rs_q     <= rs_d;
          runcnt_q <= runcnt_d;
        end
        if (c_keep) begin
          if (!seen_q) begin
            lo_q <= wr_idx;
          end
          hi_q   <= tok_len_q + LEN_W'(1);
          seen_q <= 1'b1;
        end
      end
      if (cmd_i.set_any) begin
        any_q <= 1'b1;
      end
      if (cmd_i.init_walk) begin
        idx_q   <= lo_q;
        w_in_q  <= 1'b0;
        w_obf_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        idx_q  <= idx_q + IDX_W'(1);
        w_in_q <= b_alpha || (w_in_q && b_sub);
        if (b_alpha && !w_in_q) begin
          w_obf_q <= obf_q[idx_q];
        end
      end
      if (cmd_i.clear) begin
        tok_len_q  <= '0;
        ovf_q      <= 1'b0;
        seen_q     <= 1'b0;
        p1_in_q    <= 1'b0;
        p1_alpha_q <= 1'b0;
        p2_alpha_q <= 1'b0;
        runcnt_q   <= '0;
        if (eot_q) begin
          prev_q <= '0;
          rcnt_q <= '0;
          any_q  <= 1'b0;
        end
      end
      if (produce) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (load_pend || cmd_i.marker) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr) begin
      sand_q[wr_idx] <= 1'b0;
      if (sandwich) begin
        sand_q[wr_idx - IDX_W'(1)] <= 1'b1;
      end
      if (cur_in) begin
        obf_q[rs_d] <= (runcnt_d == 2'd2);
      end
    end
    if (produce) begin
      pend_byte_q  <= prod_byte;
      pend_trunc_q <= ovf_q;
    end
    if (load_pend) begin
      out_byte_q  <= pend_byte_q;
      out_has_q   <= 1'b1;
      out_trunc_q <= pend_trunc_q;
      out_last_q  <= cmd_i.flush;
      out_done_q  <= cmd_i.flush && eot_q;
    end else if (cmd_i.marker) begin
      out_byte_q  <= '0;
      out_has_q   <= 1'b0;
      out_trunc_q <= 1'b0;
      out_last_q  <= 1'b1;
      out_done_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_trunc_q, out_done_q, out_has_q};

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_len_q <= LEN_W'(ttn_pkg::TOKEN_MAX))
    else $error("token length past buffer size");

  a_flush_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |-> pend_v_q)
    else $error("flush without pending result");

  a_produce_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.put_space || cmd_i.emit_cur) |-> (!pend_v_q || !out_v_q || m_axis_tready_i))
    else $error("result produced with no room");

  a_trim_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> ((LEN_W'(lo_q) < hi_q) && (hi_q <= tok_len_q)))
    else $error("trim bounds outside token");

endmodule

// ===== hdl/text_token_normalizer.sv =====
// Top level of the text token normalizer: controller, datapath and buffer.
//
// Input stream: one text byte per transfer, tlast on the last byte of a text.
// Output stream: one normalized byte per transfer; tlast marks the last result
// caused by an input byte, tuser carries has_byte, text_done, token_truncated.
// cfg_we_i loads the repeat limit (reset value 2); write it only while idle.
// A byte that does not end a token is accepted and gives no result.
// A whitespace byte or a tlast byte releases the buffered token: the byte is
// taken, the walk is set up, each byte of the trimmed token gets one RAM read
// and one decision step, and the result is closed, with s_axis_tready_o low
// from setup through close. Bytes dropped by the obfuscation rule still take
// their read and decision steps. Results pass through a one-entry holding
// register so that tlast can be set on the last one.
// A tlast byte that yields nothing returns one empty marker result.
// Reset empties the token, clears the repeat tracker and needs no clearing pass.
// A stalled receiver holds the output register; the walk waits once both the
// holding register and the output register are full.
module text_token_normalizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] in_byte
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,  // [7:0] out_byte
  output logic                        m_axis_tlast_o,
  output logic [ttn_pkg::TUSER_W-1:0] m_axis_tuser_o,  // [2] token_truncated, [1] text_done, [0] has_byte
  input  logic                        cfg_we_i,
  input  logic [7:0]                  cfg_wdata_i
);

  ttn_pkg::cmd_t cmd;
  ttn_pkg::sts_t sts;

  ttn_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  ttn_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
